// ===== rtl/fpesc_pkg.sv =====
// Package: shared constants, codes and control types of the frustum cull block.
`default_nettype none
package fpesc_pkg;

    localparam int PLANE_COUNT  = 6;
    localparam int FRAC_BITS    = 16;
    localparam int COEF_W       = 32;
    localparam int PLANE_IDX_W  = $clog2(PLANE_COUNT);
    localparam int SQRT_STEPS   = 32;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_TEST   = 2'd2,
        ACT_DIRTY  = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_MAT_WR,
        OP_SET_DIRTY,
        OP_BUILD_A,
        OP_BUILD_B,
        OP_SQ_MUL,
        OP_SQ_ACC,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_STORE,
        OP_UPD_END,
        OP_TEST_INIT,
        OP_T_MUL,
        OP_T_ACC,
        OP_T_CMP,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_BUILD_A,
        S_BUILD_B,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT_INIT,
        S_SQRT,
        S_SQRT_CHK,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_STORE,
        S_UPD_END,
        S_T_MUL,
        S_T_ACC
    } ctrl_state_t;

    typedef struct packed {
        logic                   capture;
        dp_op_t                 op;
        logic [PLANE_IDX_W-1:0] plane;
        logic [1:0]             j;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    dirty;
        logic    len_zero;
        logic    fail;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/fpesc_ctrl.sv =====
// Controller: sequences matrix writes, mark-dirty requests, plane updates and sphere tests.
`default_nettype none
module fpesc_ctrl #(
    parameter int FRAC_BITS = fpesc_pkg::FRAC_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    output fpesc_pkg::dp_cmd_t         cmd,
    input  wire fpesc_pkg::dp_status_t status
);
    import fpesc_pkg::*;

    localparam int DIV_W = COEF_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
    localparam logic [PLANE_IDX_W-1:0] PLANE_LAST = PLANE_IDX_W'(PLANE_COUNT - 1);

    ctrl_state_t            state_reg, state_next;
    logic [PLANE_IDX_W-1:0] plane_reg, plane_next;
    logic [1:0]             j_reg, j_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            plane_reg <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            plane_reg <= plane_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        plane_next = plane_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                plane_next = '0;
                j_next     = '0;
                case (status.action)
                    ACT_UPDATE: state_next = status.dirty ? S_BUILD_A : S_IDLE;
                    ACT_TEST:   state_next = S_T_MUL;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_BUILD_A:
            begin
                state_next = S_BUILD_B;
            end
            S_BUILD_B:
            begin
                j_next     = j_reg + 2'd1;
                state_next = (j_reg == 2'd3) ? S_SQ_MUL : S_BUILD_A;
            end
            S_SQ_MUL:
            begin
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                if (j_reg == 2'd2)
                begin
                    j_next     = '0;
                    state_next = S_SQRT_INIT;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_SQ_MUL;
                end
            end
            S_SQRT_INIT:
            begin
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = S_SQRT_CHK;
                end
            end
            S_SQRT_CHK:
            begin
                j_next     = '0;
                state_next = status.len_zero ? S_STORE : S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                j_next     = j_reg + 2'd1;
                state_next = (j_reg == 2'd3) ? S_STORE : S_DIV_INIT;
            end
            S_STORE:
            begin
                j_next = '0;
                if (plane_reg == PLANE_LAST)
                begin
                    state_next = S_UPD_END;
                end
                else
                begin
                    plane_next = plane_reg + PLANE_IDX_W'(1);
                    state_next = S_BUILD_A;
                end
            end
            S_UPD_END:
            begin
                state_next = S_IDLE;
            end
            S_T_MUL:
            begin
                j_next = j_reg + 2'd1;
                if (j_reg == 2'd2)
                begin
                    state_next = S_T_ACC;
                end
            end
            S_T_ACC:
            begin
                j_next = '0;
                if (status.fail || plane_reg == PLANE_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    plane_next = plane_reg + PLANE_IDX_W'(1);
                    state_next = S_T_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.op      = OP_NONE;
        cmd.plane   = plane_reg;
        cmd.j       = j_reg;
        busy        = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = start;
            end
            S_DISPATCH:
            begin
                case (status.action)
                    ACT_WRITE:  cmd.op = OP_MAT_WR;
                    ACT_DIRTY:  cmd.op = OP_SET_DIRTY;
                    ACT_TEST:   cmd.op = OP_TEST_INIT;
                    default:    cmd.op = status.dirty ? OP_NONE : OP_FINISH;
                endcase
                if (status.action == ACT_WRITE || status.action == ACT_DIRTY)
                begin
                    cmd.op = (status.action == ACT_WRITE) ? OP_MAT_WR : OP_SET_DIRTY;
                end
            end
            S_BUILD_A:   cmd.op = OP_BUILD_A;
            S_BUILD_B:   cmd.op = OP_BUILD_B;
            S_SQ_MUL:    cmd.op = OP_SQ_MUL;
            S_SQ_ACC:    cmd.op = OP_SQ_ACC;
            S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
            S_SQRT:      cmd.op = OP_SQRT_STEP;
            S_DIV_INIT:  cmd.op = OP_DIV_INIT;
            S_DIV:       cmd.op = OP_DIV_STEP;
            S_DIV_END:   cmd.op = OP_DIV_END;
            S_STORE:     cmd.op = OP_STORE;
            S_UPD_END:   cmd.op = OP_UPD_END;
            S_T_MUL:     cmd.op = OP_T_MUL;
            S_T_ACC:     cmd.op = OP_T_CMP;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/fpesc_datapath.sv =====
// Datapath: matrix and plane storage, shared multiplier, square root and divider.
`default_nettype none
module fpesc_datapath #(
    parameter int FRAC_BITS = fpesc_pkg::FRAC_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire fpesc_pkg::dp_cmd_t        cmd,
    output fpesc_pkg::dp_status_t          status,
    input  wire logic [1:0]                action,
    input  wire logic [3:0]                elem_index,
    input  wire logic signed [31:0]        elem_value,
    input  wire logic signed [31:0]        center_x,
    input  wire logic signed [31:0]        center_y,
    input  wire logic signed [31:0]        center_z,
    input  wire logic [30:0]               radius,
    output logic                           done,
    output logic                           visible,
    output logic                           planes_updated,
    output logic                           saturated
);
    import fpesc_pkg::*;

    localparam int DIV_W = COEF_W + FRAC_BITS;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    logic signed [31:0] matrix_reg [16];
    logic signed [31:0] plane_reg  [PLANE_COUNT][4];
    logic               dirty_reg;

    action_t            act_reg;
    logic [3:0]         idx_reg;
    logic signed [31:0] val_reg, cx_reg, cy_reg, cz_reg;
    logic [30:0]        rad_reg;

    logic signed [31:0] hold_reg;
    logic signed [31:0] v_reg [4];
    logic signed [63:0] prod_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        n_reg, res_reg, bit_reg;
    logic [31:0]        rem_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic               neg_reg;
    logic signed [65:0] acc_reg;

    logic sat_acc_reg;
    logic done_reg, visible_reg, updated_reg, saturated_reg;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [1:0]         col_k;
    logic signed [32:0] build_sum;
    logic signed [31:0] build_val;
    logic               build_sat;
    logic [63:0]        sqrt_try;
    logic [31:0]        len;
    logic [32:0]        div_t;
    logic               div_ge;
    logic [31:0]        mag;
    logic signed [31:0] div_val;
    logic               div_sat;
    logic signed [65:0] acc_sum;
    logic signed [65:0] acc_sh;
    logic signed [66:0] plane_dist;
    logic signed [66:0] neg_r;
    logic signed [31:0] coef;
    logic signed [31:0] coef_d;
    logic               finish;

    assign coef   = plane_reg[cmd.plane][cmd.j];
    assign coef_d = plane_reg[cmd.plane][3];
    assign col_k  = cmd.plane[2:1];
    assign len    = res_reg[31:0];

    always_comb
    begin
        mul_a = v_reg[cmd.j];
        mul_b = v_reg[cmd.j];
        if (cmd.op == OP_T_MUL)
        begin
            mul_a = coef;
            case (cmd.j)
                2'd0:    mul_b = cx_reg;
                2'd1:    mul_b = cy_reg;
                default: mul_b = cz_reg;
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        if (cmd.plane[0])
        begin
            build_sum = 33'(hold_reg) - 33'(matrix_reg[{cmd.j, col_k}]);
        end
        else
        begin
            build_sum = 33'(hold_reg) + 33'(matrix_reg[{cmd.j, col_k}]);
        end
        build_sat = (build_sum[32] != build_sum[31]);
        if (!build_sat)
        begin
            build_val = build_sum[31:0];
        end
        else if (build_sum[32])
        begin
            build_val = S32_MIN;
        end
        else
        begin
            build_val = S32_MAX;
        end
    end

    assign sqrt_try = res_reg + bit_reg;
    assign div_t    = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge   = (div_t >= {1'b0, len});
    assign mag      = v_reg[cmd.j][31] ? 32'(-33'(v_reg[cmd.j])) : v_reg[cmd.j];

    always_comb
    begin
        div_sat = 1'b0;
        div_val = 32'(quo_reg);
        if (!neg_reg)
        begin
            if (quo_reg > DIV_W'(S32_MAX))
            begin
                div_sat = 1'b1;
                div_val = S32_MAX;
            end
        end
        else
        begin
            if (quo_reg > DIV_W'(33'h1_0000_0000 >> 1))
            begin
                div_sat = 1'b1;
                div_val = S32_MIN;
            end
            else
            begin
                div_val = 32'(-quo_reg);
            end
        end
    end

    assign acc_sum    = acc_reg + 66'(prod_reg);
    assign acc_sh     = acc_sum >>> FRAC_BITS;
    assign plane_dist = 67'(acc_sh) + 67'(coef_d);
    assign neg_r      = -$signed({36'd0, rad_reg});

    assign status.action   = act_reg;
    assign status.dirty    = dirty_reg;
    assign status.len_zero = (res_reg == 64'd0);
    assign status.fail     = (plane_dist < neg_r);

    assign finish = cmd.op == OP_MAT_WR || cmd.op == OP_SET_DIRTY || cmd.op == OP_UPD_END
                    || cmd.op == OP_FINISH || (cmd.op == OP_T_CMP
                    && (status.fail || cmd.plane == PLANE_IDX_W'(PLANE_COUNT - 1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                matrix_reg[i] <= '0;
            end
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    plane_reg[p][c] <= '0;
                end
            end
            dirty_reg     <= 1'b1;
            sat_acc_reg   <= 1'b0;
            done_reg      <= 1'b0;
            visible_reg   <= 1'b0;
            updated_reg   <= 1'b0;
            saturated_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
            if (cmd.capture)
            begin
                sat_acc_reg <= 1'b0;
            end
            case (cmd.op)
                OP_MAT_WR:
                begin
                    matrix_reg[idx_reg] <= val_reg;
                end
                OP_SET_DIRTY:
                begin
                    dirty_reg <= 1'b1;
                end
                OP_BUILD_B:
                begin
                    if (build_sat)
                    begin
                        sat_acc_reg <= 1'b1;
                    end
                end
                OP_DIV_END:
                begin
                    if (div_sat)
                    begin
                        sat_acc_reg <= 1'b1;
                    end
                end
                OP_STORE:
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        plane_reg[cmd.plane][c] <= v_reg[c];
                    end
                end
                OP_UPD_END:
                begin
                    dirty_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
            if (finish)
            begin
                visible_reg   <= (cmd.op == OP_T_CMP) ? !status.fail : 1'b0;
                updated_reg   <= (cmd.op == OP_UPD_END);
                saturated_reg <= (cmd.op == OP_UPD_END) ? sat_acc_reg : 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action_t'(action);
            idx_reg <= elem_index;
            val_reg <= elem_value;
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            cz_reg  <= center_z;
            rad_reg <= radius;
        end
        case (cmd.op)
            OP_BUILD_A:
            begin
                hold_reg <= matrix_reg[{cmd.j, 2'd3}];
            end
            OP_BUILD_B:
            begin
                v_reg[cmd.j] <= build_val;
            end
            OP_SQ_MUL:
            begin
                prod_reg <= mul_p;
            end
            OP_SQ_ACC:
            begin
                sq_reg <= ((cmd.j == 2'd0) ? 64'd0 : sq_reg) + 64'(prod_reg);
            end
            OP_SQRT_INIT:
            begin
                n_reg   <= sq_reg;
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
            end
            OP_SQRT_STEP:
            begin
                if (n_reg >= sqrt_try)
                begin
                    n_reg   <= n_reg - sqrt_try;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_DIV_INIT:
            begin
                rem_reg <= '0;
                quo_reg <= {mag, FRAC_BITS'(0)};
                neg_reg <= v_reg[cmd.j][31];
            end
            OP_DIV_STEP:
            begin
                if (div_ge)
                begin
                    rem_reg <= 32'(div_t - {1'b0, len});
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_t[31:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                end
            end
            OP_DIV_END:
            begin
                v_reg[cmd.j] <= div_val;
            end
            OP_T_MUL:
            begin
                prod_reg <= mul_p;
                acc_reg  <= (cmd.j == 2'd0) ? 66'sd0 : acc_sum;
            end
            OP_T_ACC:
            begin
                acc_reg <= acc_sum;
            end
            default:
            begin
            end
        endcase
    end

    assign done           = done_reg;
    assign visible        = visible_reg & done_reg;
    assign planes_updated = updated_reg & done_reg;
    assign saturated      = saturated_reg & done_reg;

endmodule
`default_nettype wire

// ===== rtl/frustum_plane_extract_sphere_cull_top.sv =====
// Top level: frustum plane extraction and sphere cull, controller plus datapath.
`default_nettype none
// A request is taken when start is high and busy is low; its one result appears on
// visible, planes_updated and saturated for the single cycle in which done is high,
// and the receiver cannot stall it. Matrix writes, mark-dirty and clean updates give
// done from the dispatch state through the done register. A sphere test walks the
// stored planes one at a time through the shared multiplier and stops at the first
// plane that rejects the sphere. A dirty update runs per plane eight matrix reads,
// three squares, a 32-step square root and, when the length is nonzero, four
// restoring divisions of 32+FRAC_BITS steps each, FRAC_BITS being 16 for Q16.16.
// Tests read the stored planes even while they are marked dirty.
module frustum_plane_extract_sphere_cull_top #(
    parameter int FRAC_BITS = fpesc_pkg::FRAC_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         action,
    input  wire logic [3:0]         elem_index,
    input  wire logic signed [31:0] elem_value,
    input  wire logic signed [31:0] center_x,
    input  wire logic signed [31:0] center_y,
    input  wire logic signed [31:0] center_z,
    input  wire logic [30:0]        radius,
    output logic                    done,
    output logic                    visible,
    output logic                    planes_updated,
    output logic                    saturated
);
    import fpesc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    fpesc_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    fpesc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .action         (action),
        .elem_index     (elem_index),
        .elem_value     (elem_value),
        .center_x       (center_x),
        .center_y       (center_y),
        .center_z       (center_z),
        .radius         (radius),
        .done           (done),
        .visible        (visible),
        .planes_updated (planes_updated),
        .saturated      (saturated)
    );

endmodule
`default_nettype wire

// ===== tb/tb_frustum_plane_extract_sphere_cull_top.sv =====
// Testbench for the frustum plane extraction and sphere cull block.
`default_nettype none
module tb_frustum_plane_extract_sphere_cull_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fpesc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic vis;
        logic upd;
        logic sat;
    } cull_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         action;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
    logic               done;
    logic               visible;
    logic               planes_updated;
    logic               saturated;

    logic signed [31:0] mat_shadow [16];
    logic signed [31:0] plane_shadow [PLANE_COUNT*4];
    logic               dirty_shadow;
    cull_result_t       expected_q [$];
    int                 error_count;
    int                 request_count;
    int                 result_count;
    int                 idle_cycles;
    int                 test_count;
    int                 update_count;

    frustum_plane_extract_sphere_cull_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .elem_index(elem_index), .elem_value(elem_value), .center_x(center_x),
        .center_y(center_y), .center_z(center_z), .radius(radius), .done(done),
        .visible(visible), .planes_updated(planes_updated), .saturated(saturated)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v,
                                                   inout logic sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic extract_planes();
        logic sat;
        logic signed [31:0] v [4];
        logic signed [63:0] s;
        logic signed [63:0] num;
        logic [63:0] sq;
        logic [63:0] len;
        logic [63:0] m;
        int k;
        sat = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            k = p >> 1;
            s = (p & 1) ? -64'sd1 : 64'sd1;
            for (int j = 0; j < 4; j++)
                v[j] = clamp32(64'(mat_shadow[4*j+3]) + s * 64'(mat_shadow[4*j+k]), sat);
            sq = 0;
            for (int j = 0; j < 3; j++)
            begin
                m = (v[j] < 0) ? -64'(v[j]) : 64'(v[j]);
                sq = sq + m * m;
            end
            len = int_sqrt(sq);
            if (len != 0)
                for (int j = 0; j < 4; j++)
                begin
                    num = 64'(v[j]) <<< FRAC_BITS;
                    v[j] = clamp32(num / $signed(len), sat);
                end
            for (int j = 0; j < 4; j++)
                plane_shadow[4*p+j] = v[j];
        end
        return sat;
    endfunction

    function automatic logic sphere_in_frustum(input logic signed [31:0] x,
                                               input logic signed [31:0] y,
                                               input logic signed [31:0] z,
                                               input logic [30:0] r);
        logic signed [95:0] dot;
        logic signed [95:0] plane_dist;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            dot = 96'(plane_shadow[4*p]) * 96'(x) + 96'(plane_shadow[4*p+1]) * 96'(y)
                + 96'(plane_shadow[4*p+2]) * 96'(z);
            plane_dist = (dot >>> FRAC_BITS) + 96'(plane_shadow[4*p+3]);
            if (plane_dist < -96'(signed'({1'b0, r})))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("mismatch on %s at result %0d: got %0b, expected %0b",
                 what, result_count, got, want);
        error_count++;
    endtask

    task automatic send_request(input action_t act, input logic [3:0] idx,
                                input logic signed [31:0] val,
                                input logic signed [31:0] x, input logic signed [31:0] y,
                                input logic signed [31:0] z, input logic [30:0] r);
        cull_result_t res;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
            : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        elem_index <= idx;
        elem_value <= val;
        center_x <= x;
        center_y <= y;
        center_z <= z;
        radius <= r;
        do
            @(posedge clk);
        while (busy);
        res = '0;
        case (act)
            ACT_WRITE:
                mat_shadow[idx] = val;
            ACT_UPDATE:
                if (dirty_shadow)
                begin
                    res.sat = extract_planes();
                    res.upd = 1'b1;
                    dirty_shadow = 1'b0;
                    update_count++;
                end
            ACT_TEST:
            begin
                res.vis = sphere_in_frustum(x, y, z, r);
                test_count++;
            end
            default:
                dirty_shadow = 1'b1;
        endcase
        expected_q.push_back(res);
        request_count++;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return 32'sd65536 * $signed($urandom_range(0, 8) - 4);
            4: return $urandom;
            default: return $signed($urandom_range(0, 32'h00080000)) - 32'sh00040000;
        endcase
    endfunction

    function automatic logic [30:0] pick_radius();
        case ($urandom_range(0, 4))
            0: return 31'h7fffffff;
            1: return 31'd0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h00040000));
        endcase
    endfunction

    task automatic load_matrix(input bit identity_like);
        for (int i = 0; i < 16; i++)
            send_request(ACT_WRITE, i[3:0],
                         identity_like ? ((i % 5 == 0) ? 32'sd65536 : 32'sd0) : pick_value(),
                         0, 0, 0, 0);
    endtask

    task automatic test_directed();
        send_request(ACT_TEST, 0, 0, 0, 0, 0, 0);
        send_request(ACT_UPDATE, 0, 0, 0, 0, 0, 0);
        send_request(ACT_UPDATE, 0, 0, 0, 0, 0, 0);
        send_request(ACT_WRITE, 4'd15, 32'sh7fffffff, 0, 0, 0, 0);
        send_request(ACT_WRITE, 4'd3, 32'sh7fffffff, 0, 0, 0, 0);
        send_request(ACT_WRITE, 4'd0, 32'sh80000000, 0, 0, 0, 0);
        send_request(ACT_UPDATE, 0, 0, 0, 0, 0, 0);
        send_request(ACT_DIRTY, 0, 0, 0, 0, 0, 0);
        send_request(ACT_TEST, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
        send_request(ACT_UPDATE, 0, 0, 0, 0, 0, 0);
        send_request(ACT_TEST, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     31'h7fffffff);
        send_request(ACT_TEST, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    endtask

    task automatic test_identity_frustum();
        load_matrix(1'b1);
        send_request(ACT_DIRTY, 0, 0, 0, 0, 0, 0);
        send_request(ACT_UPDATE, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 6; i++)
            send_request(ACT_TEST, 0, 0, pick_value(), pick_value(), pick_value(),
                         pick_radius());
    endtask

    task automatic test_random_traffic(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                send_request(ACT_TEST, 4'($urandom), $urandom, pick_value(), pick_value(),
                             pick_value(), pick_radius());
            else if (r < 85)
                send_request(ACT_WRITE, 4'($urandom), pick_value(), $urandom, $urandom,
                             $urandom, 31'($urandom));
            else if (r < 92)
                send_request(ACT_DIRTY, 4'($urandom), $urandom, $urandom, $urandom,
                             $urandom, 31'($urandom));
            else
                send_request(ACT_UPDATE, 4'($urandom), $urandom, $urandom, $urandom,
                             $urandom, 31'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", done, 1'b0);
            end
            else
            begin
                cull_result_t want;
                want = expected_q.pop_front();
                if (visible !== want.vis)
                    report_mismatch("visible", visible, want.vis);
                if (planes_updated !== want.upd)
                    report_mismatch("planes_updated", planes_updated, want.upd);
                if (saturated !== want.sat)
                    report_mismatch("saturated", saturated, want.sat);
            end
            result_count++;
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_WRITE;
        elem_index = '0;
        elem_value = '0;
        center_x = '0;
        center_y = '0;
        center_z = '0;
        radius = '0;
        error_count = 0;
        request_count = 0;
        result_count = 0;
        idle_cycles = 0;
        test_count = 0;
        update_count = 0;
        foreach (mat_shadow[i])
            mat_shadow[i] = '0;
        foreach (plane_shadow[i])
            plane_shadow[i] = '0;
        dirty_shadow = 1'b1;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_identity_frustum();
        test_random_traffic(1080);
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
        $display("covered %0d requests: %0d sphere tests, %0d plane recomputations",
                 request_count, test_count, update_count);
        if (error_count == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
